@@ src/lsfp_pkg.sv @@
// Shared types and constants for the line sensor frame parser.
package lsfp_pkg;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_DIG   = 8'h44;
	localparam logic [7:0] CH_ANA   = 8'h41;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [2:0] MAX_DIGITS = 3'd5;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_DIG  = 2'd1;
	localparam logic [1:0] KIND_ANA  = 2'd2;

	localparam logic [1:0] LINK_OK    = 2'd0;
	localparam logic [1:0] LINK_STALE = 2'd1;
	localparam logic [1:0] LINK_NONE  = 2'd2;

	typedef enum logic [3:0] {
		PH_KIND      = 4'd0,
		PH_COMMA     = 4'd1,
		PH_X         = 4'd2,
		PH_IDX_FIRST = 4'd3,
		PH_IDX       = 4'd4,
		PH_VAL_FIRST = 4'd5,
		PH_VAL       = 4'd6
	} phase_t;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  byte_in;
		logic [31:0] time_ms;
	} in_t;

	typedef struct packed {
		logic        frame_accepted;
		logic [1:0]  frame_kind;
		logic [7:0]  digital_bits;
		logic [63:0] analog_ch1_4;
		logic [63:0] analog_ch5_8;
		logic        digital_fresh;
		logic        analog_fresh;
		logic [1:0]  link_status;
		logic [15:0] bad_frames;
		logic [15:0] overflow_frames;
		logic [15:0] digital_frames;
		logic [15:0] analog_frames;
	} out_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

@@ src/line_sensor_frame_parser.sv @@
// Top level: byte-serial line sensor frame parser with status reporting.
// Takes one request (a received byte or a status query) per cycle and returns
// one status result in the cycle after. The grammar check, value staging and
// commit for a byte are done in one pass between the input handshake and the
// output register, so the rate is one request per clock as long as the output
// side does not stall. No clearing pass after reset.
module line_sensor_frame_parser #(
	parameter int CHANNELS      = 8,
	parameter int BODY_CAPACITY = 128,
	parameter int ANALOG_MAX    = 4095
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lsfp_pkg::in_t       in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lsfp_pkg::out_t      out_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);
	import lsfp_pkg::*;

	localparam logic [3:0]  CH_LAST = 4'(CHANNELS);
	localparam logic [7:0]  BODY_CAP = 8'(BODY_CAPACITY);
	localparam logic [16:0] ANA_LIM = 17'(ANALOG_MAX);

	logic        in_frame_q, in_frame_n;
	logic [7:0]  body_len_q, body_len_n;
	phase_t      phase_q, phase_n;
	logic [3:0]  chan_q, chan_n;
	logic [3:0]  idx_q, idx_n;
	logic [16:0] val_q, val_n;
	logic [2:0]  digits_q, digits_n;
	logic        err_q, err_n;
	logic        kind_q, kind_n;
	logic [15:0] staged_q [8];
	logic [15:0] staged_n [8];
	logic [7:0]  dig_store_q, dig_store_n;
	logic [15:0] ana_store_q [8];
	logic [15:0] ana_store_n [8];
	logic [31:0] dig_stamp_q, dig_stamp_n;
	logic [31:0] ana_stamp_q, ana_stamp_n;
	logic [15:0] cnt_bad_q, cnt_bad_n, cnt_ovf_q, cnt_ovf_n;
	logic [15:0] cnt_dig_q, cnt_dig_n, cnt_ana_q, cnt_ana_n;
	logic [15:0] max_age_q;
	logic [1:0]  kind_out;
	logic        accept;
	out_t        res;

	assign in_stall = out_valid & out_stall;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		logic [7:0]  b;
		logic [3:0]  d;
		logic        is_dig;
		logic [7:0]  idx_mul;
		logic [16:0] lim;
		logic        stage;
		logic        close_ok;
		b        = in_data.byte_in;
		d        = 4'(b - CH_ZERO);
		is_dig   = b inside {[CH_ZERO:CH_NINE]};
		idx_mul  = {4'd0, idx_q} * 8'd10 + {4'd0, d};
		lim      = kind_q ? ANA_LIM : 17'd1;
		stage    = 1'b0;
		close_ok = 1'b0;
		in_frame_n = in_frame_q;
		body_len_n = body_len_q;
		phase_n    = phase_q;
		chan_n     = chan_q;
		idx_n      = idx_q;
		val_n      = val_q;
		digits_n   = digits_q;
		err_n      = err_q;
		kind_n     = kind_q;
		staged_n   = staged_q;
		dig_store_n = dig_store_q;
		ana_store_n = ana_store_q;
		dig_stamp_n = dig_stamp_q;
		ana_stamp_n = ana_stamp_q;
		cnt_bad_n = cnt_bad_q;
		cnt_ovf_n = cnt_ovf_q;
		cnt_dig_n = cnt_dig_q;
		cnt_ana_n = cnt_ana_q;
		kind_out  = KIND_NONE;
		if (accept && in_data.opcode == OP_BYTE) begin
			if (b == CH_START) begin
				in_frame_n = 1'b1;
				body_len_n = 8'd0;
				phase_n    = PH_KIND;
				chan_n     = 4'd0;
				idx_n      = 4'd0;
				val_n      = 17'd0;
				digits_n   = 3'd0;
				err_n      = 1'b0;
				kind_n     = 1'b0;
			end else if (in_frame_q) begin
				if (b == CH_END) begin
					in_frame_n = 1'b0;
					if (!err_q && phase_q == PH_VAL && chan_q == CH_LAST && val_q <= lim) begin
						close_ok = 1'b1;
						stage    = 1'b1;
					end
				end else if (b == CH_CR || b == CH_LF) begin
					in_frame_n = in_frame_q;
				end else if (body_len_q >= BODY_CAP) begin
					in_frame_n = 1'b0;
					body_len_n = 8'd0;
					cnt_ovf_n  = sat_inc(cnt_ovf_q);
				end else begin
					body_len_n = body_len_q + 8'd1;
					if (!err_q) begin
						case (phase_q)
							PH_KIND: begin
								if (b == CH_DIG) begin
									kind_n = 1'b0; phase_n = PH_COMMA;
								end else if (b == CH_ANA) begin
									kind_n = 1'b1; phase_n = PH_COMMA;
								end else err_n = 1'b1;
							end
							PH_COMMA: begin
								if (b == CH_COMMA) begin
									chan_n = 4'd1; phase_n = PH_X;
								end else err_n = 1'b1;
							end
							PH_X: begin
								if (b == CH_X) phase_n = PH_IDX_FIRST;
								else err_n = 1'b1;
							end
							PH_IDX_FIRST: begin
								if (is_dig) begin
									idx_n = d; phase_n = PH_IDX;
								end else err_n = 1'b1;
							end
							PH_IDX: begin
								if (is_dig) begin
									idx_n = (idx_mul > 8'd15) ? 4'd15 : idx_mul[3:0];
								end else if (b == CH_COLON && idx_q == chan_q) begin
									phase_n = PH_VAL_FIRST;
								end else err_n = 1'b1;
							end
							PH_VAL_FIRST: begin
								if (is_dig) begin
									val_n = {13'd0, d}; digits_n = 3'd1; phase_n = PH_VAL;
								end else err_n = 1'b1;
							end
							PH_VAL: begin
								if (is_dig) begin
									if (digits_q >= MAX_DIGITS) err_n = 1'b1;
									else begin
										val_n = (val_q << 3) + (val_q << 1) + {13'd0, d};
										digits_n = digits_q + 3'd1;
									end
								end else if (b == CH_COMMA && chan_q < CH_LAST) begin
									if (val_q > lim) err_n = 1'b1;
									else stage = 1'b1;
									chan_n  = chan_q + 4'd1;
									phase_n = PH_X;
								end else err_n = 1'b1;
							end
							default: err_n = 1'b1;
						endcase
					end
				end
			end
		end
		if (stage)
			staged_n[3'(chan_q - 4'd1)] = val_q[15:0];
		if (accept && in_data.opcode == OP_BYTE && in_frame_q && b == CH_END
			&& b != CH_START) begin
			if (!close_ok) begin
				err_n     = 1'b1;
				cnt_bad_n = sat_inc(cnt_bad_q);
			end else if (!kind_q) begin
				for (int i = 0; i < CHANNELS; i++)
					dig_store_n[i] = staged_n[i][0];
				dig_stamp_n = in_data.time_ms;
				cnt_dig_n   = sat_inc(cnt_dig_q);
				kind_out    = KIND_DIG;
			end else begin
				for (int i = 0; i < CHANNELS; i++)
					ana_store_n[i] = staged_n[i];
				ana_stamp_n = in_data.time_ms;
				cnt_ana_n   = sat_inc(cnt_ana_q);
				kind_out    = KIND_ANA;
			end
		end
	end

	always_comb begin
		logic [31:0] now;
		logic [31:0] newer;
		logic        newer_fresh;
		now   = in_data.time_ms;
		newer = (dig_stamp_n > ana_stamp_n) ? dig_stamp_n : ana_stamp_n;
		newer_fresh = (newer != 32'd0) && ((now - newer) <= {16'd0, max_age_q});
		res.frame_accepted = (kind_out != KIND_NONE);
		res.frame_kind     = kind_out;
		res.digital_bits   = dig_store_n;
		res.analog_ch1_4   = {ana_store_n[3], ana_store_n[2], ana_store_n[1], ana_store_n[0]};
		res.analog_ch5_8   = {ana_store_n[7], ana_store_n[6], ana_store_n[5], ana_store_n[4]};
		res.digital_fresh  = (dig_stamp_n != 32'd0)
			&& ((now - dig_stamp_n) <= {16'd0, max_age_q});
		res.analog_fresh   = (ana_stamp_n != 32'd0)
			&& ((now - ana_stamp_n) <= {16'd0, max_age_q});
		if (cnt_dig_n == 16'd0 && cnt_ana_n == 16'd0) res.link_status = LINK_NONE;
		else res.link_status = newer_fresh ? LINK_OK : LINK_STALE;
		res.bad_frames      = cnt_bad_n;
		res.overflow_frames = cnt_ovf_n;
		res.digital_frames  = cnt_dig_n;
		res.analog_frames   = cnt_ana_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			body_len_q <= 8'd0;
			phase_q    <= PH_KIND;
			chan_q     <= 4'd0;
			idx_q      <= 4'd0;
			val_q      <= 17'd0;
			digits_q   <= 3'd0;
			err_q      <= 1'b0;
			kind_q     <= 1'b0;
			dig_store_q <= 8'hFF;
			for (int i = 0; i < 8; i++) ana_store_q[i] <= 16'hFFFF;
			dig_stamp_q <= 32'd0;
			ana_stamp_q <= 32'd0;
			cnt_bad_q <= 16'd0;
			cnt_ovf_q <= 16'd0;
			cnt_dig_q <= 16'd0;
			cnt_ana_q <= 16'd0;
			max_age_q <= 16'd100;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) max_age_q <= cfg_data;
			if (accept) begin
				in_frame_q <= in_frame_n;
				body_len_q <= body_len_n;
				phase_q    <= phase_n;
				chan_q     <= chan_n;
				idx_q      <= idx_n;
				val_q      <= val_n;
				digits_q   <= digits_n;
				err_q      <= err_n;
				kind_q     <= kind_n;
				dig_store_q <= dig_store_n;
				ana_store_q <= ana_store_n;
				dig_stamp_q <= dig_stamp_n;
				ana_stamp_q <= ana_stamp_n;
				cnt_bad_q <= cnt_bad_n;
				cnt_ovf_q <= cnt_ovf_n;
				cnt_dig_q <= cnt_dig_n;
				cnt_ana_q <= cnt_ana_n;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			staged_q <= staged_n;
			out_data <= res;
		end
	end

`ifndef SYNTHESIS
	a_accept_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_accepted |-> out_data.frame_kind != KIND_NONE)
		else $error("accepted frame without kind");
	a_dig_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_kind == KIND_DIG |-> out_data.digital_frames != 16'd0)
		else $error("digital frame not counted");
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.digital_frames != 16'd0 || out_data.analog_frames != 16'd0)
		|-> out_data.link_status != LINK_NONE)
		else $error("link reported none after a frame");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
`endif

endmodule
